// ----- design/crt_pkg.sv -----
package crt_pkg;

   localparam int unsigned KIND_W  = 2;
   localparam int unsigned ID_W    = 8;
   localparam int unsigned USED_W  = 5;
   localparam int unsigned REQ_W   = 16;
   localparam int unsigned RSP_W   = 24;

   localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GRANT    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_scan;
      logic scan_done;
      logic rsp_free;
   } status_type;

endpackage

// ----- design/crt_ram.sv -----
module crt_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/crt_ctrl.sv -----
module crt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  crt_pkg::status_type status,
   output crt_pkg::cmd_type    cmd
);

   crt_pkg::state_type state_ff;
   crt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         crt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = status.needs_scan ? crt_pkg::ST_SCAN : crt_pkg::ST_FINISH;
            end
         end
         crt_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = crt_pkg::ST_FINISH;
            end
         end
         crt_pkg::ST_FINISH: begin
            // wait for the result register to drain
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = crt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = crt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/crt_datapath.sv -----
module crt_datapath #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [crt_pkg::KIND_W-1:0]    req_kind,
   input  logic [crt_pkg::REQ_W-1:0]     req_data,
   input  logic                          csr_we,
   input  logic [crt_pkg::ID_W-1:0]      csr_data,
   input  crt_pkg::cmd_type              cmd,
   output crt_pkg::status_type           status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [crt_pkg::RSP_W-1:0]     rsp_data
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned IW = crt_pkg::ID_W;

   logic [crt_pkg::KIND_W-1:0] kind_ff;
   logic [IW-1:0]              id_ff;
   logic [IW-1:0]              val_ff;
   logic [IW-1:0]              parent_ff;
   logic [CW-1:0]              count_ff, count_in;
   logic [IW-1:0]              quota_ff, quota_in;
   logic [CW-1:0]              idx_ff;
   logic                       cmp_valid_ff;
   logic                       found_ff;
   logic [IW-1:0]              hop_ff;
   logic                       rsp_valid_ff;
   logic [crt_pkg::RSP_W-1:0]  rsp_data_ff;

   logic [2*IW-1:0] ram_rdata;
   logic            ram_we;
   logic            issue;
   logic            hit;
   logic            room;
   logic            reg_ok;
   logic            res_accepted;
   logic            res_found;
   logic [IW-1:0]   res_hop;

   // entry word: hop in the upper byte, id in the lower
   crt_ram #(
      .WIDTH (2 * IW),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[AW-1:0]),
      .wdata ({val_ff, id_ff}),
      .raddr (idx_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   assign issue = cmd.scan && (idx_ff < count_ff);
   assign hit   = cmp_valid_ff && (ram_rdata[IW-1:0] == id_ff);
   assign room  = count_ff < CW'(TABLE_DEPTH);

   assign reg_ok = (kind_ff == crt_pkg::KIND_REGISTER) && (quota_ff != '0);
   assign ram_we = cmd.finish && reg_ok && !found_ff && room;

   always_comb begin
      res_accepted = 1'b0;
      res_found    = 1'b0;
      res_hop      = '0;
      count_in     = count_ff;
      quota_in     = quota_ff;
      unique case (kind_ff)
         crt_pkg::KIND_REGISTER: begin
            res_accepted = reg_ok && (found_ff || room);
            if (ram_we) begin
               count_in = count_ff + 1'b1;
               quota_in = quota_ff - 1'b1;
            end
         end
         crt_pkg::KIND_LOOKUP: begin
            res_found = found_ff;
            res_hop   = found_ff ? hop_ff : parent_ff;
         end
         crt_pkg::KIND_GRANT: begin
            res_accepted = 1'b1;
            quota_in     = val_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         quota_ff     <= '0;
         parent_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            parent_ff <= csr_data;
         end
         if (cmd.load) begin
            cmp_valid_ff <= 1'b0;
         end else if (cmd.scan) begin
            cmp_valid_ff <= issue;
         end
         if (cmd.finish) begin
            count_ff     <= count_in;
            quota_ff     <= quota_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         id_ff    <= req_data[IW-1:0];
         val_ff   <= req_data[2*IW-1:IW];
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan) begin
         if (issue) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (hit) begin
            found_ff <= 1'b1;
            hop_ff   <= ram_rdata[2*IW-1:IW];
         end
      end
      if (cmd.finish) begin
         rsp_data_ff <= {1'b0, quota_in, crt_pkg::USED_W'(count_in), res_hop,
                         res_found, res_accepted};
      end
   end

   assign status.needs_scan = (req_kind == crt_pkg::KIND_REGISTER)
                           || (req_kind == crt_pkg::KIND_LOOKUP);
   assign status.scan_done  = hit || (idx_ff >= count_ff);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (count_ff == $past(count_ff) + 1'b1) && (quota_ff == $past(quota_ff) - 1'b1))
      else $error("append did not move count and quota together");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   a_found_lookup: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[1]) |-> !rsp_data_ff[0])
      else $error("lookup hit reported as accepted");

endmodule

// ----- design/child_route_table.sv -----
// child route table of a tree-routed mesh node
//
// req channel: one request per item. req_tuser carries the kind (register a
// descendant, look up a next hop, grant quota); req_tdata carries device id
// and next hop or quota. csr channel: writes the parent id, always ready;
// write it only while the block is idle.
// rsp channel: exactly one result per request, in request order.
//
// lookups and registrations walk the stored entries one per cycle through a
// registered-read ram, stopping at the first match. a request is taken in
// the idle state only, so one request is handled at a time; the next request
// is taken the cycle after the result is loaded, and a result waiting in the
// output register does not block it.
// if the receiver stalls, the result is held and the following request is
// walked but not finished until the output register frees up.
// reset clears the entry count, the quota and the parent id; the table
// itself needs no clearing pass since only entries below the count are read.
module child_route_table #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // kind
   input  logic [15:0] req_tdata,   // device_id, hop_or_quota
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // accepted, found, next_hop, entries_used, quota_left
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [7:0]  csr_tdata    // parent_id
);

   crt_pkg::cmd_type    cmd;
   crt_pkg::status_type status;

   assign csr_tready = 1'b1;

   crt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   crt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_kind  (req_tuser),
      .req_data  (req_tdata),
      .csr_we    (csr_tvalid),
      .csr_data  (csr_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

endmodule

// ----- tb/tb_child_route_table.sv -----
`timescale 1ns / 100ps

module tb_child_route_table;

   localparam int unsigned TABLE_DEPTH = 16;
   localparam logic [crt_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int unsigned IDLE_PCT    = 12;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned PHASE_ITEMS = 375;

   typedef struct packed {
      logic                       accepted;
      logic                       found;
      logic [crt_pkg::ID_W-1:0]   next_hop;
      logic [crt_pkg::USED_W-1:0] entries_used;
      logic [7:0]                 quota_left;
   } route_reply_type;

   typedef struct {
      logic [crt_pkg::KIND_W-1:0] kind;
      logic [crt_pkg::ID_W-1:0]   id;
      logic [7:0]                 arg;
      int unsigned                reps;
      bit                         typed;
      route_reply_type            want;
   } route_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // kind
   logic [15:0] req_tdata;   // device_id, hop_or_quota
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // accepted, found, next_hop, entries_used, quota_left
   logic        csr_tvalid;
   logic        csr_tready;
   logic [7:0]  csr_tdata;   // parent_id

   // table as the block should hold it
   logic [crt_pkg::ID_W-1:0] tbl_ids [TABLE_DEPTH];
   logic [7:0]               tbl_hops [TABLE_DEPTH];
   int unsigned              tbl_count;
   logic [7:0]               tbl_quota;
   logic [crt_pkg::ID_W-1:0] tbl_parent;

   route_reply_type pending_replies[$];
   route_row_type   directed_rows[$];
   int unsigned     fault_count = 0;
   bit              steady = 1'b0;
   bit              hold_request = 1'b0;
   bit              hold_served = 1'b0;

   child_route_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic route_reply_type predict_reply(
         input logic [crt_pkg::KIND_W-1:0] kind,
         input logic [crt_pkg::ID_W-1:0] id,
         input logic [7:0] arg);
      route_reply_type r;
      int              hit;
      r = '0;
      hit = -1;
      // first match from the bottom of the table
      for (int i = 0; i < int'(tbl_count); i++) begin
         if (hit < 0 && tbl_ids[i] == id)
            hit = i;
      end
      case (kind)
         crt_pkg::KIND_REGISTER: begin
            if (tbl_quota != 8'd0) begin
               if (hit >= 0) begin
                  r.accepted = 1'b1;
               end else if (tbl_count < TABLE_DEPTH) begin
                  tbl_ids[tbl_count] = id;
                  tbl_hops[tbl_count] = arg;
                  tbl_count++;
                  tbl_quota = tbl_quota - 8'd1;
                  r.accepted = 1'b1;
               end
            end
         end
         crt_pkg::KIND_LOOKUP: begin
            r.found = (hit >= 0);
            r.next_hop = (hit >= 0) ? tbl_hops[hit] : tbl_parent;
         end
         crt_pkg::KIND_GRANT: begin
            tbl_quota = arg;
            r.accepted = 1'b1;
         end
         default: ;
      endcase
      r.entries_used = crt_pkg::USED_W'(tbl_count);
      r.quota_left = tbl_quota;
      return r;
   endfunction

   // entered and left at a falling edge
   task automatic push_request(input logic [crt_pkg::KIND_W-1:0] kind,
                               input logic [crt_pkg::ID_W-1:0] id,
                               input logic [7:0] arg, input bit typed,
                               input route_reply_type want);
      route_reply_type r;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {arg, id};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      r = predict_reply(kind, id, arg);
      pending_replies.push_back(typed ? want : r);
      @(negedge clock);
   endtask

   task automatic write_parent(input logic [7:0] value);
      while (pending_replies.size() != 0)
         @(negedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata <= value;
      @(posedge clock);
      while (!csr_tready)
         @(posedge clock);
      tbl_parent = value;
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   task automatic add_row(input logic [crt_pkg::KIND_W-1:0] kind,
                          input logic [crt_pkg::ID_W-1:0] id,
                          input logic [7:0] arg, input int unsigned reps, input bit typed,
                          input route_reply_type want);
      route_row_type row;
      row.kind = kind;
      row.id = id;
      row.arg = arg;
      row.reps = reps;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   // receiver side
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin : reply_check
      route_reply_type got;
      route_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[0], rsp_tdata[1], rsp_tdata[9:2], rsp_tdata[14:10],
                rsp_tdata[22:15]};
         if (pending_replies.size() == 0) begin
            fault_count++;
            $display("%0t: reply with none pending: acc %0d found %0d hop %h used %0d quota %h",
                     $time, got.accepted, got.found, got.next_hop, got.entries_used,
                     got.quota_left);
         end else begin
            want = pending_replies.pop_front();
            if (got !== want) begin
               fault_count++;
               $display("%0t: expected acc %0d found %0d hop %h used %0d quota %h",
                        $time, want.accepted, want.found, want.next_hop, want.entries_used,
                        want.quota_left);
               $display("%0t:   actual acc %0d found %0d hop %h used %0d quota %h",
                        $time, got.accepted, got.found, got.next_hop, got.entries_used,
                        got.quota_left);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int unsigned                pick;
      logic [crt_pkg::KIND_W-1:0] kind;
      logic [crt_pkg::ID_W-1:0]   id;
      logic [7:0]                 arg;
      route_row_type              row;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = crt_pkg::KIND_REGISTER;
      req_tdata = 16'h0000;
      csr_tvalid = 1'b0;
      csr_tdata = 8'h00;
      tbl_count = 0;
      tbl_quota = 8'h00;
      tbl_parent = 8'h00;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table, no quota, then a table filled to the brim
      add_row(crt_pkg::KIND_LOOKUP,   8'h00, 8'h00, 1,  1'b1,
              {1'b0, 1'b0, 8'hFF, 5'd0, 8'h00});
      add_row(crt_pkg::KIND_REGISTER, 8'h12, 8'h34, 1,  1'b1,
              {1'b0, 1'b0, 8'h00, 5'd0, 8'h00});
      add_row(KIND_UNUSED,            8'hFF, 8'hFF, 1,  1'b1,
              {1'b0, 1'b0, 8'h00, 5'd0, 8'h00});
      add_row(crt_pkg::KIND_GRANT,    8'h00, 8'hFF, 1,  1'b1,
              {1'b1, 1'b0, 8'h00, 5'd0, 8'hFF});
      add_row(crt_pkg::KIND_REGISTER, 8'h00, 8'hFF, 1,  1'b0, '0);
      add_row(crt_pkg::KIND_REGISTER, 8'hFF, 8'h00, 1,  1'b0, '0);
      add_row(crt_pkg::KIND_REGISTER, 8'h00, 8'h55, 1,  1'b0, '0);   // known id, hop kept
      add_row(crt_pkg::KIND_LOOKUP,   8'h00, 8'h00, 1,  1'b0, '0);
      add_row(crt_pkg::KIND_LOOKUP,   8'hFF, 8'hFF, 1,  1'b0, '0);
      add_row(crt_pkg::KIND_LOOKUP,   8'h80, 8'h00, 1,  1'b0, '0);
      add_row(KIND_UNUSED,            8'h00, 8'h00, 1,  1'b0, '0);
      add_row(crt_pkg::KIND_GRANT,    8'h00, 8'h00, 1,  1'b1,
              {1'b1, 1'b0, 8'h00, 5'd2, 8'h00});
      add_row(crt_pkg::KIND_REGISTER, 8'hFF, 8'h11, 1,  1'b0, '0);   // known id, but no quota
      add_row(crt_pkg::KIND_GRANT,    8'hAA, 8'h0F, 1,  1'b0, '0);
      add_row(crt_pkg::KIND_REGISTER, 8'h10, 8'hA0, 14, 1'b0, '0);
      add_row(crt_pkg::KIND_REGISTER, 8'h7F, 8'h7F, 1,  1'b0, '0);   // full, quota left
      add_row(crt_pkg::KIND_REGISTER, 8'h1D, 8'h00, 1,  1'b0, '0);
      add_row(crt_pkg::KIND_LOOKUP,   8'h1D, 8'h00, 1,  1'b0, '0);
      add_row(crt_pkg::KIND_LOOKUP,   8'h81, 8'h00, 1,  1'b0, '0);
      add_row(crt_pkg::KIND_LOOKUP,   8'h10, 8'h00, 1,  1'b0, '0);
      add_row(crt_pkg::KIND_GRANT,    8'h55, 8'hFF, 1,  1'b0, '0);

      write_parent(8'hFF);
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         for (int k = 0; k < int'(row.reps); k++)
            push_request(row.kind, row.id + 8'(k), row.arg + 8'(k), row.typed, row.want);
      end
      req_tvalid <= 1'b0;

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_parent(8'h00);
            2: write_parent(8'hFF);
            default: write_parent(8'($urandom_range(255)));
         endcase
         steady = (ph == 2);
         if (ph == 1)
            hold_request = 1'b1;
         for (int n = 0; n < int'(PHASE_ITEMS); n++) begin
            pick = $urandom_range(99);
            id = 8'($urandom_range(255));
            arg = 8'($urandom_range(255));
            if (pick < 45) begin
               kind = crt_pkg::KIND_LOOKUP;
               if (tbl_count > 0 && $urandom_range(3) != 0)
                  id = tbl_ids[$urandom_range(tbl_count - 1)];
            end else if (pick < 75) begin
               kind = crt_pkg::KIND_REGISTER;
               if (tbl_count > 0 && $urandom_range(1) != 0)
                  id = tbl_ids[$urandom_range(tbl_count - 1)];
            end else if (pick < 93) begin
               kind = crt_pkg::KIND_GRANT;
               // half of them tiny quotas so refusals for lack of quota come often
               case ($urandom_range(3))
                  0: arg = 8'h00;
                  1: arg = 8'($urandom_range(3));
                  default: ;
               endcase
            end else begin
               kind = KIND_UNUSED;
            end
            push_request(kind, id, arg, 1'b0, '0);
         end
         req_tvalid <= 1'b0;
      end

      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (fault_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
